>>> design/xml_entity_decoder_top_assert.svh
// assertion macros used by the checker file
`ifndef XML_ENTITY_DECODER_TOP_ASSERT_SVH
`define XML_ENTITY_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define XED_ASSERT_SAME(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("xml entity decoder check failed");

// next-cycle implication
`define XED_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("xml entity decoder check failed");

`endif

>>> design/xed_pkg.sv
package xed_pkg;

   localparam int unsigned NumEntities = 5;
   localparam int unsigned NameLen     = 5;
   localparam int unsigned HeldMax     = 4;
   localparam int unsigned MaxResults  = 6;
   localparam int unsigned LimitWidth  = 16;

   localparam logic [LimitWidth-1:0] LimitReset = 16'hFFFF;
   localparam logic [7:0]            AmpChar    = 8'h26;
   localparam logic [7:0]            NulChar    = 8'h00;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } xed_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
      logic       truncated;
   } xed_rsp_type;

   // one decoded request: up to six bytes, sent in order by the back end
   typedef struct packed {
      logic [MaxResults-1:0][7:0] data_bytes;
      logic [2:0]                 count;
      logic                       last;
      logic                       truncated;
   } xed_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } xed_queue_status_type;

   // entity names, element j is character j of the name
   function automatic logic [NameLen-1:0][7:0] entity_name(input logic [2:0] idx);
      logic [NameLen-1:0][7:0] name;
      unique case (idx)
         3'd0:    name = {8'h3b, 8'h74, 8'h6f, 8'h75, 8'h71}; // quot;
         3'd1:    name = {8'h3b, 8'h73, 8'h6f, 8'h70, 8'h61}; // apos;
         3'd2:    name = {8'h00, 8'h00, 8'h3b, 8'h74, 8'h6c}; // lt;
         3'd3:    name = {8'h00, 8'h00, 8'h3b, 8'h74, 8'h67}; // gt;
         3'd4:    name = {8'h00, 8'h3b, 8'h70, 8'h6d, 8'h61}; // amp;
         default: name = '0;
      endcase
      return name;
   endfunction

   function automatic logic [2:0] entity_len(input logic [2:0] idx);
      logic [2:0] len;
      unique case (idx)
         3'd0:    len = 3'd5;
         3'd1:    len = 3'd5;
         3'd2:    len = 3'd3;
         3'd3:    len = 3'd3;
         3'd4:    len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] entity_value(input logic [2:0] idx);
      logic [7:0] value;
      unique case (idx)
         3'd0:    value = 8'h22;
         3'd1:    value = 8'h27;
         3'd2:    value = 8'h3c;
         3'd3:    value = 8'h3e;
         3'd4:    value = 8'h26;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

>>> design/xed_front.sv
module xed_front
   import xed_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [LimitWidth-1:0] csr_write_data,
   input  logic                  req_valid,
   input  xed_req_type           req_data,
   output logic                  req_stall,
   input  xed_queue_status_type  queue_status,
   output logic                  push_valid,
   output xed_job_type           push_job
);

   localparam int unsigned CmpWidth = (COUNT_WIDTH > LimitWidth) ? COUNT_WIDTH : LimitWidth;
   localparam logic [CmpWidth-1:0] CountMax = CmpWidth'((64'd1 << COUNT_WIDTH) - 64'd1);

   logic [LimitWidth-1:0]    output_limit_ff;
   logic                     in_entity_ff, in_entity_in;
   logic [HeldMax-1:0][7:0]  held_chars_ff, held_chars_in;
   logic [2:0]               held_count_ff, held_count_in;
   logic [COUNT_WIDTH-1:0]   emitted_count_ff, emitted_count_in;
   logic                     overflowed_ff, overflowed_in;

   logic                     accept;
   logic [7:0]               c;
   logic [2:0]               n;
   logic [3:0]               n_plus;
   logic [NameLen-1:0][7:0]  cand;
   logic [NameLen-1:0][7:0]  name_cur;
   logic [3:0]               len_cur;
   logic                     eq_cur;
   logic                     full_hit, prefix_hit;
   logic [7:0]               hit_value;
   logic                     plain_now;
   logic [MaxResults-1:0][7:0] seq;
   logic [2:0]               seq_count;
   logic [CmpWidth-1:0]      limit_eff, count_ext, room;
   logic [2:0]               emit;
   logic                     drop;

   assign accept    = req_valid && !req_stall;
   assign req_stall = queue_status.full;
   assign c         = req_data.in_byte;
   assign n         = held_count_ff;
   assign n_plus    = {1'b0, n} + 4'd1;

   // match the held name plus the new byte against all five names at once
   always_comb begin
      for (int j = 0; j < HeldMax; j++) begin
         cand[j] = (3'(j) < n) ? held_chars_ff[j] : ((3'(j) == n) ? c : 8'h00);
      end
      cand[NameLen-1] = (n == 3'(HeldMax)) ? c : 8'h00;
      full_hit   = 1'b0;
      prefix_hit = 1'b0;
      hit_value  = 8'h00;
      name_cur   = '0;
      len_cur    = 4'd0;
      eq_cur     = 1'b0;
      for (int i = 0; i < NumEntities; i++) begin
         name_cur = entity_name(3'(i));
         len_cur  = {1'b0, entity_len(3'(i))};
         eq_cur   = 1'b1;
         for (int j = 0; j < NameLen; j++) begin
            if (3'(j) <= n && cand[j] != name_cur[j]) begin
               eq_cur = 1'b0;
            end
         end
         if (eq_cur && n_plus <= len_cur) begin
            if (n_plus == len_cur) begin
               full_hit  = 1'b1;
               hit_value = entity_value(3'(i));
            end else begin
               prefix_hit = 1'b1;
            end
         end
      end
   end

   // build the byte sequence this request produces
   always_comb begin
      seq           = '0;
      seq_count     = 3'd0;
      in_entity_in  = in_entity_ff;
      held_chars_in = held_chars_ff;
      held_count_in = held_count_ff;
      plain_now     = 1'b0;

      if (in_entity_ff) begin
         if (full_hit) begin
            seq[seq_count] = hit_value;
            seq_count      = seq_count + 3'd1;
            in_entity_in   = 1'b0;
            held_chars_in  = '0;
            held_count_in  = 3'd0;
         end else if (prefix_hit && n < 3'(HeldMax)) begin
            held_chars_in[n[1:0]] = c;
            held_count_in         = n + 3'd1;
         end else begin
            // mismatch: ampersand and held text go out literally
            seq[seq_count] = AmpChar;
            seq_count      = seq_count + 3'd1;
            for (int k = 0; k < HeldMax; k++) begin
               if (3'(k) < n && seq_count < 3'(MaxResults)) begin
                  seq[seq_count] = held_chars_ff[k];
                  seq_count      = seq_count + 3'd1;
               end
            end
            in_entity_in  = 1'b0;
            held_chars_in = '0;
            held_count_in = 3'd0;
            plain_now     = 1'b1;
         end
      end else begin
         plain_now = 1'b1;
      end

      if (plain_now) begin
         if (c == AmpChar) begin
            in_entity_in  = 1'b1;
            held_chars_in = '0;
            held_count_in = 3'd0;
         end else if (seq_count < 3'(MaxResults)) begin
            seq[seq_count] = c;
            seq_count      = seq_count + 3'd1;
         end
      end

      // partial match left at stream end is flushed
      if (req_data.in_last && in_entity_in) begin
         if (seq_count < 3'(MaxResults)) begin
            seq[seq_count] = AmpChar;
            seq_count      = seq_count + 3'd1;
         end
         for (int k = 0; k < HeldMax; k++) begin
            if (3'(k) < held_count_in && seq_count < 3'(MaxResults)) begin
               seq[seq_count] = held_chars_in[k];
               seq_count      = seq_count + 3'd1;
            end
         end
      end

      if (req_data.in_last) begin
         in_entity_in  = 1'b0;
         held_chars_in = '0;
         held_count_in = 3'd0;
      end
   end

   // output limit, also capped by a full counter
   always_comb begin
      limit_eff = (CmpWidth'(output_limit_ff) < CountMax) ? CmpWidth'(output_limit_ff) : CountMax;
      count_ext = CmpWidth'(emitted_count_ff);
      room      = (count_ext < limit_eff) ? (limit_eff - count_ext) : '0;
      drop      = room < CmpWidth'(seq_count);
      emit      = drop ? room[2:0] : seq_count;
      overflowed_in    = overflowed_ff | drop;
      emitted_count_in = emitted_count_ff + COUNT_WIDTH'(emit);
   end

   always_comb begin
      push_valid          = accept && (emit != 3'd0 || req_data.in_last);
      push_job.last       = req_data.in_last;
      if (emit != 3'd0) begin
         push_job.data_bytes = seq;
         push_job.count      = emit;
         push_job.truncated  = overflowed_ff;
      end else begin
         // empty end marker
         push_job.data_bytes = '0;
         push_job.data_bytes[0] = NulChar;
         push_job.count      = 3'd1;
         push_job.truncated  = overflowed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_limit_ff  <= LimitReset;
         in_entity_ff     <= 1'b0;
         held_chars_ff    <= '0;
         held_count_ff    <= 3'd0;
         emitted_count_ff <= '0;
         overflowed_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            output_limit_ff <= csr_write_data;
         end
         if (accept) begin
            in_entity_ff  <= in_entity_in;
            held_chars_ff <= held_chars_in;
            held_count_ff <= held_count_in;
            if (req_data.in_last) begin
               emitted_count_ff <= '0;
               overflowed_ff    <= 1'b0;
            end else begin
               emitted_count_ff <= emitted_count_in;
               overflowed_ff    <= overflowed_in;
            end
         end
      end
   end

endmodule

>>> design/xed_queue.sv
module xed_queue
   import xed_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  xed_job_type          push_job,
   input  logic                 pop,
   output xed_queue_status_type status,
   output xed_job_type          head
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);

   xed_job_type           slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]   count_ff;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == CntWidth'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> design/xed_back.sv
module xed_back
   import xed_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  xed_queue_status_type queue_status,
   input  xed_job_type          head,
   output logic                 pop,
   output logic                 rsp_valid,
   output xed_rsp_type          rsp_data,
   input  logic                 rsp_stall
);

   logic [2:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   xed_rsp_type rsp_data_ff, rsp_data_in;
   logic        load, last_of_job;

   assign load        = (!rsp_valid_ff || !rsp_stall) && !queue_status.empty;
   assign last_of_job = (pos_ff == head.count - 3'd1);
   assign pop         = load && last_of_job;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   always_comb begin
      rsp_data_in.out_byte   = head.data_bytes[pos_ff];
      rsp_data_in.run_last   = last_of_job;
      rsp_data_in.stream_end = last_of_job && head.last;
      rsp_data_in.truncated  = head.truncated;
      pos_in = pos_ff;
      if (load) begin
         pos_in = last_of_job ? 3'd0 : pos_ff + 3'd1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/xml_entity_decoder_top.sv
// channel   direction  handshake                payload
// req       in         req_valid / req_stall    xed_req_type (in_byte, in_last)
// rsp       out        rsp_valid / rsp_stall    xed_rsp_type (out_byte, run_last,
//                                               stream_end, truncated)
// csr       in         csr_write_en             csr_write_data (output_limit)
//
// one request per cycle enters while the job queue has room; the front end
// matches all five entity names in the same cycle it takes the byte
// the back end sends one result per cycle while rsp_stall is low, and a request
// yields up to 6 results; the queue of QUEUE_DEPTH jobs absorbs bursts
// reset is synchronous; no clearing pass
// req_stall rises only when the queue is full; rsp_stall freezes the output
// register, and the queue keeps taking requests meanwhile
module xml_entity_decoder_top
   import xed_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16,
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [LimitWidth-1:0] csr_write_data,
   input  logic                  req_valid,
   input  xed_req_type           req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output xed_rsp_type           rsp_data,
   input  logic                  rsp_stall
);

   // front to queue
   logic                 push_valid;
   xed_job_type          push_job;
   // queue to back
   xed_queue_status_type queue_status;
   xed_job_type          head;
   logic                 pop;

   // front: entity matching, held text, output limit and stream state
   xed_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_data       (req_data),
      .req_stall      (req_stall),
      .queue_status   (queue_status),
      .push_valid     (push_valid),
      .push_job       (push_job)
   );

   // decoded jobs wait here so that each side can stall on its own
   xed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .status     (queue_status),
      .head       (head)
   );

   // back: walks each job one byte at a time into the output register
   xed_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_stall    (rsp_stall)
   );

endmodule

>>> design/xed_checker.sv
`include "xml_entity_decoder_top_assert.svh"

module xed_checker
   import xed_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input xed_rsp_type           rsp_data,
   input logic                  rsp_stall
);

   // end of stream always closes a request's run
   `XED_ASSERT_SAME(a_end_is_run_last, clock, reset, rsp_valid && rsp_data.stream_end, rsp_data.run_last)

   // the rest of a run follows in the very next cycle
   `XED_ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_data.run_last, rsp_valid)

   // a stalled result stays put
   `XED_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // nothing comes out right after reset
   `XED_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind xml_entity_decoder_top xed_checker u_checker (.*);

>>> tb/xml_entity_decoder_top_test.sv
`timescale 1ns / 100ps

module xml_entity_decoder_top_test;
   import xed_pkg::*;

   // block configuration under test
   localparam int unsigned CountWidth   = 16;
   localparam int unsigned QueueDepth   = 4;
   // quiet cycles after the last result, enough for a full job queue to drain
   localparam int unsigned SettleCycles = 8 + QueueDepth * MaxResults;
   // watchdog bound on the cycles of the whole run
   localparam int unsigned CycleLimit   = 400000;
   // random requests per limit setting
   localparam int unsigned PhaseItems   = 45;
   // long receiver hold-off, started once this many requests have gone in
   localparam int unsigned HoldAfter    = 50;
   localparam int unsigned HoldCycles   = 200;

   // expected decoder output, built one accepted request at a time
   class entity_scoreboard #(int unsigned CNT_W = 16);
      string                 ent_name[5] = '{"quot;", "apos;", "lt;", "gt;", "amp;"};
      logic [7:0]            ent_char[5] = '{8'h22, 8'h27, 8'h3c, 8'h3e, 8'h26};
      logic [LimitWidth-1:0] out_limit   = LimitReset;
      bit                    in_entity;
      logic [7:0]            held_text[HeldMax];
      int unsigned           held_len;
      longint unsigned       emitted;
      bit                    overflowed;
      logic [7:0]            step_bytes[$];
      bit                    step_trunc[$];
      xed_rsp_type           expected_rsp[$];
      int unsigned           mismatches, results_seen, entities_hit, trunc_seen, end_markers;

      function void set_limit(logic [LimitWidth-1:0] value);
         out_limit = value;
      endfunction

      function int unsigned outstanding();
         return expected_rsp.size();
      endfunction

      function void emit(logic [7:0] value);
         longint unsigned cnt_max;
         cnt_max = (64'd1 << CNT_W) - 1;
         if (emitted < out_limit && emitted < cnt_max && step_bytes.size() < MaxResults) begin
            step_bytes.push_back(value);
            step_trunc.push_back(overflowed);
            emitted++;
         end else begin
            overflowed = 1'b1;
         end
      endfunction

      function void clear_match();
         in_entity = 1'b0;
         held_len  = 0;
      endfunction

      function void flush_held();
         if (!in_entity) return;
         emit(AmpChar);
         for (int i = 0; i < held_len; i++) emit(held_text[i]);
         clear_match();
      endfunction

      function void take_plain(logic [7:0] value);
         if (value == AmpChar) begin
            in_entity = 1'b1;
            held_len  = 0;
         end else begin
            emit(value);
         end
      endfunction

      function void take_name_byte(logic [7:0] value);
         logic [7:0]  cand[HeldMax+1];
         int unsigned n;
         bit          prefix;
         bit          hit;
         n      = held_len;
         prefix = 1'b0;
         for (int i = 0; i < n; i++) cand[i] = held_text[i];
         cand[n] = value;
         for (int e = 0; e < 5; e++) begin
            if (n + 1 <= ent_name[e].len()) begin
               hit = 1'b1;
               for (int j = 0; j <= n; j++)
                  if (cand[j] != 8'(ent_name[e][j])) hit = 1'b0;
               if (hit) begin
                  if (n + 1 == ent_name[e].len()) begin
                     clear_match();
                     entities_hit++;
                     emit(ent_char[e]);
                     return;
                  end
                  prefix = 1'b1;
               end
            end
         end
         if (prefix && n < HeldMax) begin
            held_text[n] = value;
            held_len     = n + 1;
            return;
         end
         flush_held();
         take_plain(value);
      endfunction

      function void note_request(xed_req_type req);
         xed_rsp_type item;
         bit          fin;
         step_bytes.delete();
         step_trunc.delete();
         if (in_entity) take_name_byte(req.in_byte);
         else take_plain(req.in_byte);
         if (req.in_last) begin
            flush_held();
            if (step_bytes.size() == 0) begin
               step_bytes.push_back(NulChar);
               step_trunc.push_back(overflowed);
               end_markers++;
            end
         end
         foreach (step_bytes[k]) begin
            fin             = (k == step_bytes.size() - 1);
            item.out_byte   = step_bytes[k];
            item.run_last   = fin;
            item.stream_end = fin && req.in_last;
            item.truncated  = step_trunc[k];
            expected_rsp.push_back(item);
         end
         if (req.in_last) begin
            clear_match();
            emitted    = 0;
            overflowed = 1'b0;
         end
      endfunction

      function void check_result(xed_rsp_type got);
         xed_rsp_type want;
         results_seen++;
         if (got.truncated) trunc_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.out_byte !== want.out_byte) begin
            mismatches++;
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
         end
         if (got.run_last !== want.run_last) begin
            mismatches++;
            $display("%0t: run_last expected %b actual %b", $time, want.run_last, got.run_last);
         end
         if (got.stream_end !== want.stream_end) begin
            mismatches++;
            $display("%0t: stream_end expected %b actual %b", $time,
                     want.stream_end, got.stream_end);
         end
         if (got.truncated !== want.truncated) begin
            mismatches++;
            $display("%0t: truncated expected %b actual %b", $time,
                     want.truncated, got.truncated);
         end
      endfunction
   endclass

   // block inputs all start at known values
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  csr_write_en   = 1'b0;
   logic [LimitWidth-1:0] csr_write_data = LimitReset;
   logic                  req_valid      = 1'b0;
   xed_req_type           req_data       = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   xed_rsp_type           rsp_data;
   logic                  rsp_stall      = 1'b0;

   entity_scoreboard #(CountWidth) score;

   // entity names used to build stimulus
   string       entity_names[5] = '{"quot;", "apos;", "lt;", "gt;", "amp;"};
   logic [7:0]  stream_text[$];
   bit          sender_busy;
   int unsigned requests_accepted;
   int unsigned streams_sent;
   int unsigned cycle_count;

   xml_entity_decoder_top #(
      .COUNT_WIDTH (CountWidth),
      .QUEUE_DEPTH (QueueDepth)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_data       (req_data),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .rsp_stall      (rsp_stall)
   );

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   // idle length: mostly none, often a few cycles, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // one request; valid stays high into the next request when there is no gap
   task automatic send_request(input logic [7:0] value, input logic last_flag);
      int unsigned gap;
      gap = sender_busy ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: value, in_last: last_flag};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge, req_data still holds the accepted payload
      score.note_request(req_data);
      requests_accepted++;
   endtask

   task automatic send_text(input string text, input bit close);
      for (int i = 0; i < text.len(); i++)
         send_request(8'(text[i]), close && (i == text.len() - 1));
      if (close) streams_sent++;
   endtask

   // stop offering and wait for every expected result plus the queue latency
   task automatic drain_results();
      req_valid <= 1'b0;
      while (score.outstanding() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // limit changes only while the block is idle
   task automatic set_output_limit(input logic [LimitWidth-1:0] value);
      drain_results();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      score.set_limit(value);
   endtask

   // random stream: mostly entity text, with broken names, bare ampersands and noise
   function automatic void fill_stream();
      int unsigned pieces, kind, pick, cut;
      stream_text.delete();
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
         kind = $urandom_range(0, 99);
         pick = $urandom_range(0, 4);
         if (kind < 35) begin
            // whole entity
            stream_text.push_back(AmpChar);
            for (int i = 0; i < entity_names[pick].len(); i++)
               stream_text.push_back(8'(entity_names[pick][i]));
         end else if (kind < 50) begin
            // name cut short, sometimes followed by a stray byte
            cut = $urandom_range(1, entity_names[pick].len() - 1);
            stream_text.push_back(AmpChar);
            for (int i = 0; i < cut; i++)
               stream_text.push_back(8'(entity_names[pick][i]));
            if ($urandom_range(0, 1)) stream_text.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 58) begin
            // run of ampersands
            repeat ($urandom_range(1, 3)) stream_text.push_back(AmpChar);
         end else if (kind < 82) begin
            // printable text
            repeat ($urandom_range(1, 5)) stream_text.push_back(8'($urandom_range(32, 126)));
         end else if (kind < 92) begin
            // any byte value
            stream_text.push_back(8'($urandom_range(0, 255)));
         end else begin
            // entity name with no ampersand in front
            for (int i = 0; i < entity_names[pick].len(); i++)
               stream_text.push_back(8'(entity_names[pick][i]));
         end
      end
   endfunction

   // result side: accept at every edge where valid is high and stall low
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) score.check_result(rsp_data);
   end

   // receiver stalls; one long hold-off fills the job queue and backs up requests
   initial begin : rsp_side
      int unsigned hold_left, stall_left, open_left;
      bit          hold_done, stall_next;
      hold_left  = 0;
      stall_left = 0;
      open_left  = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && requests_accepted >= HoldAfter) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (open_left > 0) begin
            open_left--;
            stall_next = 1'b0;
         end else begin
            // next stretch: free cycles, now and then a long one, then a stall
            open_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
            stall_left = pick_gap();
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // cycle counter guards against a hung block
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, score.outstanding());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      logic [LimitWidth-1:0] phase_limit[7];
      int unsigned           phase_count;
      score = new();
      requests_accepted = 0;
      streams_sent      = 0;
      sender_busy       = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes, entities, double ampersands, longest flush
      set_output_limit(LimitReset);
      send_request(8'h00, 1'b0);
      send_text("&lt;&amp;&&&quot&", 1'b1);
      // partial name at stream end gets flushed
      send_request(8'hff, 1'b0);
      send_text("&ap", 1'b1);
      // limit reached: last byte dropped, end marker carries the truncated flag
      set_output_limit(16'd2);
      send_text("abc", 1'b1);

      // random phases over several limits, the extremes among them
      phase_limit[0] = LimitReset;
      phase_limit[1] = 16'd0;
      phase_limit[2] = 16'd1;
      phase_limit[3] = 16'($urandom_range(2, 8));
      phase_limit[4] = 16'($urandom_range(9, 30));
      phase_limit[5] = LimitReset;
      phase_limit[6] = 16'($urandom_range(2, 15));
      foreach (phase_limit[p]) begin
         set_output_limit(phase_limit[p]);
         phase_count = 0;
         while (phase_count < PhaseItems) begin
            // some streams go back to back with no idle cycles
            sender_busy = ($urandom_range(0, 3) == 0);
            fill_stream();
            foreach (stream_text[i])
               send_request(stream_text[i], i == stream_text.size() - 1);
            phase_count += stream_text.size();
            streams_sent++;
         end
      end

      drain_results();
      $display("covered %0d requests in %0d streams, output limits from 0 to %0d",
               requests_accepted, streams_sent, LimitReset);
      $display("checked %0d results: %0d entities decoded, %0d truncated, %0d end markers",
               score.results_seen, score.entities_hit, score.trunc_seen, score.end_markers);
      if (score.mismatches == 0 && score.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/xed_pkg.sv
design/xed_front.sv
design/xed_queue.sv
design/xed_back.sv
design/xml_entity_decoder_top.sv
design/xed_checker.sv
tb/xml_entity_decoder_top_test.sv
